[rtl/rfo_pkg.sv]
// Package for the ring FIFO with overwrite: operation codes, default sizes
// and the memory control struct. No dependencies.
`default_nettype none

package rfo_pkg;

    localparam int unsigned DEPTH_DEF      = 64;
    localparam int unsigned ELEM_WIDTH_DEF = 8;
    localparam int unsigned OP_W           = 3;
    localparam int unsigned OFFSET_W       = 6;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH       = 3'd0,
        OP_PUSH_FORCE = 3'd1,
        OP_POP        = 3'd2,
        OP_PEEK       = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    // Strobes from the control logic to the element store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

[rtl/rfo_store.sv]
// Element store of the ring FIFO: one write port and one registered read port.
// Depends on rfo_pkg for the control struct.
`default_nettype none

module rfo_store
    import rfo_pkg::*;
#(
    parameter int unsigned AW = 6,
    parameter int unsigned EW = 8
) (
    input  wire logic          i_clk,
    input  wire t_mem_ctl      i_ctl,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [EW-1:0] i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [EW-1:0] o_rd_data
);

    localparam int unsigned N = 1 << AW;

    logic [EW-1:0] r_mem [N];
    logic [EW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // The read register only moves on a read, so it holds while the result waits.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/ring_fifo_with_overwrite_top.sv]
// Top level of the ring FIFO with overwrite: pointer logic, operation decode
// and the result register. Depends on rfo_pkg and rfo_store.
`default_nettype none

// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_operation, i_data_in, i_peek_offset
// output    out        o_valid / i_stall    o_data_out, o_accepted, o_overwrote,
//                                           o_fill_count
//
// One transaction is accepted per clock cycle as long as the output side takes
// results; each result appears the cycle after its transaction is accepted,
// as the read port of the element store is registered.
// Reset (synchronous, active low) empties the FIFO and drops any pending result;
// the stored elements are not cleared and need not be.
// While a result is held by i_stall, o_stall is raised and no new transaction
// enters, so the store's read register and the result fields stay unchanged.

module ring_fifo_with_overwrite_top
    import rfo_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [OP_W-1:0]         i_operation,
    input  wire logic [ELEM_WIDTH-1:0]   i_data_in,
    input  wire logic [OFFSET_W-1:0]     i_peek_offset,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [ELEM_WIDTH-1:0]        o_data_out,
    output logic                         o_accepted,
    output logic                         o_overwrote,
    output logic [$clog2(DEPTH):0]       o_fill_count
);

    // Address width, pointer width (one extra wrap bit) and the width used
    // to compare and add the peek offset against pointer quantities.
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned CW = (PW > OFFSET_W) ? PW : OFFSET_W;

    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic          r_out_valid;
    logic          r_accepted, n_accepted;
    logic          r_overwrote, n_overwrote;
    logic          r_use_rd, n_use_rd;
    logic [PW-1:0] r_fill_out, n_fill_out;

    t_op           op_code;
    logic          in_fire;
    logic [PW-1:0] fill;
    logic          full;
    logic          empty;
    logic [CW-1:0] peek_sum;
    logic          peek_ok;
    logic [AW-1:0] rd_addr;
    logic          do_wr;
    logic          do_rd;
    t_mem_ctl      mem_ctl;
    logic [ELEM_WIDTH-1:0] rd_data;

    assign op_code = t_op'(i_operation);

    // A transaction may enter whenever the result slot is free or is being
    // emptied in the same cycle.
    assign o_stall = r_out_valid & i_stall;
    assign in_fire = i_valid & ~o_stall;

    // The pointers wrap modulo twice the depth, so their difference is the
    // fill level and its top bit alone marks a full store.
    assign fill     = r_wr_ptr - r_rd_ptr;
    assign full     = fill[AW];
    assign empty    = (fill == '0);
    assign peek_ok  = CW'(i_peek_offset) < CW'(fill);
    assign peek_sum = CW'(r_rd_ptr) + CW'(i_peek_offset);

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_accepted  = 1'b0;
        n_overwrote = 1'b0;
        n_use_rd    = 1'b0;
        do_wr       = 1'b0;
        do_rd       = 1'b0;
        rd_addr     = r_rd_ptr[AW-1:0];
        unique case (op_code)
            OP_PUSH: begin
                if (!full) begin
                    do_wr      = 1'b1;
                    n_wr_ptr   = r_wr_ptr + PW'(1);
                    n_accepted = 1'b1;
                end
            end
            OP_PUSH_FORCE: begin
                // When full, the oldest element is given up: the slot it held
                // is exactly the one the new element is written into.
                if (full) begin
                    n_rd_ptr    = r_rd_ptr + PW'(1);
                    n_overwrote = 1'b1;
                end
                do_wr      = 1'b1;
                n_wr_ptr   = r_wr_ptr + PW'(1);
                n_accepted = 1'b1;
            end
            OP_POP: begin
                if (!empty) begin
                    do_rd      = 1'b1;
                    n_use_rd   = 1'b1;
                    n_rd_ptr   = r_rd_ptr + PW'(1);
                    n_accepted = 1'b1;
                end
            end
            OP_PEEK: begin
                if (peek_ok) begin
                    do_rd      = 1'b1;
                    n_use_rd   = 1'b1;
                    rd_addr    = peek_sum[AW-1:0];
                    n_accepted = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_wr_ptr   = '0;
                n_rd_ptr   = '0;
                n_accepted = 1'b1;
            end
            default: begin
            end
        endcase
        n_fill_out = n_wr_ptr - n_rd_ptr;
    end

    // A write and a read never target the same entry within one transaction,
    // and a later transaction reads at a later edge than any earlier write,
    // so the store needs no forwarding.
    assign mem_ctl.wr_en = in_fire & do_wr;
    assign mem_ctl.rd_en = in_fire & do_rd;

    rfo_store #(
        .AW (AW),
        .EW (ELEM_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (r_wr_ptr[AW-1:0]),
        .i_wr_data (i_data_in),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_wr_ptr <= n_wr_ptr;
                r_rd_ptr <= n_rd_ptr;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result fields; the element itself sits in the store's read register.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_accepted  <= n_accepted;
            r_overwrote <= n_overwrote;
            r_use_rd    <= n_use_rd;
            r_fill_out  <= n_fill_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data_out   = r_use_rd ? rd_data : '0;
    assign o_accepted   = r_accepted;
    assign o_overwrote  = r_overwrote;
    assign o_fill_count = r_fill_out;

    // The fill level never exceeds the depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) <= PW'(DEPTH))
        else $error("fill level beyond depth");

    // An overwrite is only reported for a stored element.
    a_ovw_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overwrote) |-> o_accepted)
        else $error("overwrite reported without acceptance");

    // Element data only comes from the store on a successful read.
    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_use_rd) |-> o_accepted)
        else $error("store data shown for failed operation");

    // A clear returns both pointers to zero.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && op_code == OP_CLEAR) |=> (r_wr_ptr == '0 && r_rd_ptr == '0))
        else $error("clear left pointers nonzero");

    // A rejected push leaves the write pointer alone.
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && op_code == OP_PUSH && full) |=> $stable(r_wr_ptr))
        else $error("push into full store moved write pointer");

endmodule

`default_nettype wire
